### src/fly_camera_pose_update_macros.svh
// Assertion macros shared by the fly camera pose update RTL.
`ifndef FLY_CAMERA_POSE_UPDATE_MACROS_SVH
`define FLY_CAMERA_POSE_UPDATE_MACROS_SVH
`ifndef SYNTHESIS
`define FCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FCP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FCP_ASSERT_IMP(lbl, ante, cons)
`define FCP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### src/fcp_pkg.sv
// Types, constants and tables of the fly camera pose update block.
package fcp_pkg;

  localparam int unsigned CordicItersDef = 16;
  localparam int unsigned CntW           = 5;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 24;

  localparam logic signed [31:0] CordicGain = 32'sd652032874;
  localparam logic signed [31:0] Deg90Q20   = 32'sd94371840;
  localparam logic signed [31:0] Deg180Q20  = 32'sd188743680;
  localparam logic [38:0]        YawMod     = 39'd23592960;
  localparam logic [38:0]        YawBias    = 39'd48318382080;
  localparam logic signed [63:0] PitchLim   = 64'sd5832704;
  localparam logic signed [63:0] QOne       = 64'sd16384;
  localparam logic [23:0]        SpeedRst   = 24'd65536;
  localparam logic [19:0]        SensRst    = 20'd6554;

  typedef enum logic {
    OP_MOVE,
    OP_LOOK
  } op_e;

  typedef enum logic [2:0] {
    DIR_FWD,
    DIR_BACK,
    DIR_LEFT,
    DIR_RIGHT,
    DIR_UP,
    DIR_DOWN
  } dir_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MOVE_SPEED,
    REG_LOOK_SENS
  } cfg_reg_e;

  typedef struct packed {
    logic               op;
    logic [2:0]         direction;
    logic [15:0]        delta_time;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [24:0]        yaw_deg;
    logic signed [23:0] pitch_deg;
  } out_item_t;

  function automatic logic signed [31:0] atan_q20(input logic [CntW-1:0] idx);
    logic signed [31:0] r;
    case (idx)
      5'd0:    r = 32'sd47185920;
      5'd1:    r = 32'sd27855475;
      5'd2:    r = 32'sd14718068;
      5'd3:    r = 32'sd7471121;
      5'd4:    r = 32'sd3750058;
      5'd5:    r = 32'sd1876857;
      5'd6:    r = 32'sd938658;
      5'd7:    r = 32'sd469357;
      5'd8:    r = 32'sd234682;
      5'd9:    r = 32'sd117342;
      5'd10:   r = 32'sd58671;
      5'd11:   r = 32'sd29335;
      5'd12:   r = 32'sd14668;
      5'd13:   r = 32'sd7334;
      5'd14:   r = 32'sd3667;
      5'd15:   r = 32'sd1833;
      5'd16:   r = 32'sd917;
      5'd17:   r = 32'sd458;
      5'd18:   r = 32'sd229;
      5'd19:   r = 32'sd115;
      5'd20:   r = 32'sd57;
      5'd21:   r = 32'sd29;
      5'd22:   r = 32'sd14;
      5'd23:   r = 32'sd7;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

### src/fcp_cordic.sv
// Rotation-mode CORDIC that gives cosine and sine, one iteration per cycle.
module fcp_cordic #(
  parameter int unsigned Iters = fcp_pkg::CordicItersDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [31:0]        angle_i,
  output logic                      done_o,
  output logic signed [31:0]        cos_o,
  output logic signed [31:0]        sin_o
);
  import fcp_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic signed [31:0]  x_q, y_q, z_q;
  logic signed [31:0]  x_d, y_d, z_d;
  logic signed [31:0]  dx, dy;

  always_comb begin
    dx = y_q >>> cnt_q;
    dy = x_q >>> cnt_q;
    if (z_q >= 0) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - atan_q20(cnt_q);
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + atan_q20(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(Iters - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CordicGain;
      y_q <= '0;
      z_q <= angle_i;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = done_q;
  assign cos_o  = x_q;
  assign sin_o  = y_q;

endmodule

### src/fly_camera_pose_update.sv
// Top level of the fly camera pose update block.
// Usage: an item enters on in_valid_i/in_item_i when in_stall_o is low. A move
// item shifts the position along front, right or up by speed times time; a look
// item turns yaw and pitch by the mouse deltas times the sensitivity. Each item
// gives one result on out_valid_o/out_item_o: the position, the orientation
// quaternion, yaw and pitch after the update.
// Registers move_speed (index 0) and look_sensitivity (index 1) are written on
// the cfg channel, which is always ready; write them only while the block idles.
// The CORDIC runs twice, and the 32x32 multiplier is used 16 times for a move
// and 6 times for a look; a look also reduces yaw by shift-subtract. The next
// item can be taken in the cycle after the result is taken.
// in_stall_o stays high from acceptance until the result has been taken, so
// one item is in flight at a time.
// While out_stall_i is high the result holds and no new item is taken.
// Reset puts the camera at the origin with zero yaw and pitch, the identity
// quaternion, and the register defaults.
`include "fly_camera_pose_update_macros.svh"
module fly_camera_pose_update #(
  parameter int unsigned CORDIC_ITERS = fcp_pkg::CordicItersDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  fcp_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output fcp_pkg::out_item_t                 out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fcp_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [fcp_pkg::CfgDataW-1:0]       cfg_data_i
);
  import fcp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_USE, S_MOD, S_CY_GO, S_CY_WAIT, S_CP_GO, S_CP_WAIT, S_OUT
  } state_e;

  typedef enum logic [4:0] {
    M_YAW, M_PITCH, M_CYA, M_CYB, M_SY, M_CPA, M_CPB, M_SP, M_VEL,
    M_V0, M_V2, M_D0, M_D1, M_D2, M_QW, M_QX, M_QY, M_QZ
  } mstep_e;

  state_e              state_q;
  mstep_e              mstep_q;
  logic [3:0]          k_q;
  in_item_t            in_q;
  logic [23:0]         speed_q;
  logic [19:0]         sens_q;
  logic signed [31:0]  pos_q [3];
  logic [24:0]         yaw_q;
  logic signed [23:0]  pitch_q;
  logic signed [15:0]  quat_q [4];

  logic signed [63:0]  mul_q, t_q;
  logic [38:0]         ymod_q;
  logic                flip_q;
  logic signed [31:0]  chy_q, shy_q, chp_q, shp_q;
  logic signed [31:0]  cy_q, sy_q, cp_q, sp_q, vel_q;
  logic signed [31:0]  v_q [3];

  logic signed [31:0]  opa, opb;
  logic signed [31:0]  hy, hy_adj, cord_angle;
  logic                hy_flip, cord_start, cord_done;
  logic signed [31:0]  cord_cos, cord_sin;
  logic signed [63:0]  r30, r46, psum;
  logic [38:0]         mod_sub, ymod_d;
  logic                is_fwd, is_right, is_up, is_neg;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] pos_add(input logic signed [31:0] p,
                                                 input logic signed [63:0] d,
                                                 input logic neg);
    logic signed [63:0] s;
    s = neg ? (64'(p) - d) : (64'(p) + d);
    if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic logic signed [15:0] sat_q14(input logic signed [63:0] v);
    if (v > QOne) return 16'(QOne);
    if (v < -QOne) return 16'(-QOne);
    return v[15:0];
  endfunction

  assign is_fwd   = (in_q.direction == DIR_FWD) || (in_q.direction == DIR_BACK);
  assign is_right = (in_q.direction == DIR_LEFT) || (in_q.direction == DIR_RIGHT);
  assign is_up    = (in_q.direction == DIR_UP) || (in_q.direction == DIR_DOWN);
  assign is_neg   = (in_q.direction == DIR_BACK) || (in_q.direction == DIR_LEFT) ||
                    (in_q.direction == DIR_DOWN);

  always_comb begin
    case (mstep_q)
      M_YAW:   begin opa = 32'(in_q.mouse_dx); opb = $signed({12'd0, sens_q}); end
      M_PITCH: begin opa = 32'(in_q.mouse_dy); opb = $signed({12'd0, sens_q}); end
      M_CYA:   begin opa = chy_q; opb = chy_q; end
      M_CYB:   begin opa = shy_q; opb = shy_q; end
      M_SY:    begin opa = shy_q; opb = chy_q; end
      M_CPA:   begin opa = chp_q; opb = chp_q; end
      M_CPB:   begin opa = shp_q; opb = shp_q; end
      M_SP:    begin opa = shp_q; opb = chp_q; end
      M_VEL:   begin opa = $signed({8'd0, speed_q}); opb = $signed({16'd0, in_q.delta_time}); end
      M_V0:    begin opa = is_fwd ? cp_q : sy_q; opb = is_fwd ? sy_q : sp_q; end
      M_V2:    begin opa = is_fwd ? cp_q : cy_q; opb = is_fwd ? cy_q : sp_q; end
      M_D0:    begin opa = vel_q; opb = v_q[0]; end
      M_D1:    begin opa = vel_q; opb = v_q[1]; end
      M_D2:    begin opa = vel_q; opb = v_q[2]; end
      M_QW:    begin opa = chy_q; opb = chp_q; end
      M_QX:    begin opa = chy_q; opb = shp_q; end
      M_QY:    begin opa = shy_q; opb = chp_q; end
      M_QZ:    begin opa = shy_q; opb = shp_q; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign r30  = rnd(mul_q, 30);
  assign r46  = rnd(mul_q, 46);
  assign psum = 64'(pitch_q) + mul_q;

  assign mod_sub = YawMod << k_q;
  assign ymod_d  = (ymod_q >= mod_sub) ? (ymod_q - mod_sub) : ymod_q;

  assign hy         = $signed({4'd0, yaw_q, 3'd0});
  assign hy_flip    = hy > Deg90Q20;
  assign hy_adj     = hy_flip ? (hy - Deg180Q20) : hy;
  assign cord_angle = (state_q == S_CY_GO) ? hy_adj : $signed({{5{pitch_q[23]}}, pitch_q, 3'd0});
  assign cord_start = (state_q == S_CY_GO) || (state_q == S_CP_GO);

  fcp_cordic #(
    .Iters(CORDIC_ITERS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (cord_angle),
    .done_o  (cord_done),
    .cos_o   (cord_cos),
    .sin_o   (cord_sin)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mstep_q   <= M_YAW;
      k_q       <= '0;
      speed_q   <= SpeedRst;
      sens_q    <= SensRst;
      pos_q[0]  <= '0;
      pos_q[1]  <= '0;
      pos_q[2]  <= '0;
      yaw_q     <= '0;
      pitch_q   <= '0;
      quat_q[0] <= 16'(QOne);
      quat_q[1] <= '0;
      quat_q[2] <= '0;
      quat_q[3] <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MOVE_SPEED: speed_q <= cfg_data_i[23:0];
          REG_LOOK_SENS:  sens_q  <= cfg_data_i[19:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_item_i.op == OP_LOOK) begin
              mstep_q <= M_YAW;
              state_q <= S_MUL;
            end else begin
              state_q <= S_CY_GO;
            end
          end
        end
        S_MUL: state_q <= S_USE;
        S_USE: begin
          case (mstep_q)
            M_PITCH: begin
              if (psum > PitchLim) pitch_q <= 24'(PitchLim);
              else if (psum < -PitchLim) pitch_q <= 24'(-PitchLim);
              else pitch_q <= psum[23:0];
            end
            M_D0: pos_q[0] <= pos_add(pos_q[0], r30, is_neg);
            M_D1: pos_q[1] <= pos_add(pos_q[1], r30, is_neg);
            M_D2: pos_q[2] <= pos_add(pos_q[2], r30, is_neg);
            M_QW: quat_q[0] <= sat_q14(r46);
            M_QX: quat_q[1] <= sat_q14(r46);
            M_QY: quat_q[2] <= sat_q14(-r46);
            M_QZ: quat_q[3] <= sat_q14(r46);
            default: ;
          endcase
          if (mstep_q == M_PITCH) begin
            k_q     <= 4'd12;
            state_q <= S_MOD;
          end else if (mstep_q == M_QZ) begin
            state_q <= S_OUT;
          end else begin
            mstep_q <= mstep_e'(mstep_q + 1'b1);
            state_q <= S_MUL;
          end
        end
        S_MOD: begin
          if (k_q == 4'd0) begin
            yaw_q   <= ymod_d[24:0];
            state_q <= S_CY_GO;
          end else begin
            k_q <= k_q - 1'b1;
          end
        end
        S_CY_GO: state_q <= S_CY_WAIT;
        S_CY_WAIT: if (cord_done) state_q <= S_CP_GO;
        S_CP_GO: state_q <= S_CP_WAIT;
        S_CP_WAIT: begin
          if (cord_done) begin
            mstep_q <= (in_q.op == OP_LOOK) ? M_QW : M_CYA;
            state_q <= S_MUL;
          end
        end
        S_OUT: if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) in_q <= in_item_i;
    if (state_q == S_MUL) mul_q <= opa * opb;
    if (state_q == S_MOD) ymod_q <= ymod_d;
    if (state_q == S_CY_GO) flip_q <= hy_flip;
    if (state_q == S_CY_WAIT && cord_done) begin
      chy_q <= flip_q ? -cord_cos : cord_cos;
      shy_q <= flip_q ? -cord_sin : cord_sin;
    end
    if (state_q == S_CP_WAIT && cord_done) begin
      chp_q <= cord_cos;
      shp_q <= cord_sin;
    end
    if (state_q == S_USE) begin
      case (mstep_q)
        M_YAW: ymod_q <= 39'(mul_q) + 39'(yaw_q) + YawBias;
        M_CYA: t_q <= mul_q;
        M_CYB: cy_q <= 32'(rnd(t_q - mul_q, 30));
        M_SY:  sy_q <= 32'(rnd(mul_q <<< 1, 30));
        M_CPA: t_q <= mul_q;
        M_CPB: cp_q <= 32'(rnd(t_q - mul_q, 30));
        M_SP:  sp_q <= 32'(rnd(mul_q <<< 1, 30));
        M_VEL: vel_q <= 32'(rnd(mul_q, 16));
        M_V0: begin
          if (is_fwd) begin
            v_q[0] <= 32'(r30);
            v_q[1] <= sp_q;
          end else if (is_right) begin
            v_q[0] <= cy_q;
            v_q[1] <= '0;
          end else if (is_up) begin
            v_q[0] <= 32'(-r30);
            v_q[1] <= cp_q;
          end else begin
            v_q[0] <= '0;
            v_q[1] <= '0;
          end
        end
        M_V2: begin
          if (is_fwd) v_q[2] <= 32'(-r30);
          else if (is_right) v_q[2] <= sy_q;
          else if (is_up) v_q[2] <= 32'(r30);
          else v_q[2] <= '0;
        end
        default: ;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cfg_ready_o = 1'b1;

  assign out_item_o.pos_x     = pos_q[0];
  assign out_item_o.pos_y     = pos_q[1];
  assign out_item_o.pos_z     = pos_q[2];
  assign out_item_o.quat_w    = quat_q[0];
  assign out_item_o.quat_x    = quat_q[1];
  assign out_item_o.quat_y    = quat_q[2];
  assign out_item_o.quat_z    = quat_q[3];
  assign out_item_o.yaw_deg   = yaw_q;
  assign out_item_o.pitch_deg = pitch_q;

  `FCP_ASSERT_IMP(a_pitch_range, 1'b1, (pitch_q <= 24'(PitchLim)) && (pitch_q >= 24'(-PitchLim)))
  `FCP_ASSERT_IMP(a_yaw_range, 1'b1, 39'(yaw_q) < YawMod)
  `FCP_ASSERT_IMP(a_cordic_done, cord_done, (state_q == S_CY_WAIT) || (state_q == S_CP_WAIT))
  `FCP_ASSERT_NXT(a_accept_busy, (state_q == S_IDLE) && in_valid_i, in_stall_o && !out_valid_o)

endmodule

### sim/tb_fly_camera_pose_update.sv
// Self-checking testbench of the fly camera pose update block with a built-in pose predictor.
module tb_fly_camera_pose_update;
  timeunit 1ns;
  timeprecision 1ps;
  import fcp_pkg::*;

  localparam int unsigned  Iters     = CordicItersDef;
  localparam longint       GainQ30   = 652032874;
  localparam longint       HalfTurn  = 94371840;
  localparam longint       FullTurn  = 188743680;
  localparam longint       YawWrap   = 23592960;
  localparam longint       PitchMax  = 5832704;
  localparam longint       QuatOne   = 16384;
  localparam longint       CycleLimit = 3000000;
  localparam logic [2:0]   DirSpareB = 3'd7;
  localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;
  localparam longint AtanTab [24] = '{47185920, 27855475, 14718068, 7471121, 3750058,
    1876857, 938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7};

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  in_item_t in_item_i;
  out_item_t out_item_o;

  fly_camera_pose_update dut (.*);

  logic signed [31:0] cam_pos [3];
  logic [24:0] cam_yaw;
  logic signed [23:0] cam_pitch;
  logic [23:0] cam_speed;
  logic [19:0] cam_sens;

  in_item_t pending_items [$];
  out_item_t pose_queue [$];
  int unsigned snd_idle_pct, rcv_stall_pct, hold_request;
  int unsigned errors, cycles;
  bit in_taken;

  function automatic longint rshr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  task automatic rotate(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = GainQ30;
    y = 0;
    z = ang;
    for (int i = 0; i < Iters && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    c = x;
    s = y;
  endtask

  function automatic logic signed [15:0] quat_part(longint v);
    if (v > QuatOne) return 16'(QuatOne);
    if (v < -QuatOne) return 16'(-QuatOne);
    return 16'(v);
  endfunction

  task automatic predict_pose(input in_item_t it, output out_item_t res);
    longint y, p, hy, chy, shy, chp, shp, cy, sy, cp, sp, vel, d, sum;
    longint vec [3];
    longint sgn;
    if (it.op == OP_LOOK) begin
      y = longint'(cam_yaw) + longint'(it.mouse_dx) * longint'(cam_sens);
      p = longint'(cam_pitch) + longint'(it.mouse_dy) * longint'(cam_sens);
      y = y % YawWrap;
      if (y < 0) y += YawWrap;
      if (p > PitchMax) p = PitchMax;
      if (p < -PitchMax) p = -PitchMax;
      cam_yaw = 25'(y);
      cam_pitch = 24'(p);
    end
    hy = longint'(cam_yaw) * 8;
    if (hy > HalfTurn) begin
      rotate(hy - FullTurn, chy, shy);
      chy = -chy;
      shy = -shy;
    end else begin
      rotate(hy, chy, shy);
    end
    rotate(longint'(cam_pitch) * 8, chp, shp);
    if (it.op == OP_MOVE) begin
      cy = rshr(chy * chy - shy * shy, 30);
      sy = rshr(2 * shy * chy, 30);
      cp = rshr(chp * chp - shp * shp, 30);
      sp = rshr(2 * shp * chp, 30);
      vel = rshr(longint'(cam_speed) * longint'(it.delta_time), 16);
      vec = '{0, 0, 0};
      sgn = 1;
      case (it.direction)
        DIR_FWD, DIR_BACK: begin
          vec = '{rshr(cp * sy, 30), sp, -rshr(cp * cy, 30)};
          if (it.direction == DIR_BACK) sgn = -1;
        end
        DIR_LEFT, DIR_RIGHT: begin
          vec = '{cy, 0, sy};
          if (it.direction == DIR_LEFT) sgn = -1;
        end
        DIR_UP, DIR_DOWN: begin
          vec = '{-rshr(sy * sp, 30), cp, rshr(cy * sp, 30)};
          if (it.direction == DIR_DOWN) sgn = -1;
        end
        default: ;
      endcase
      for (int i = 0; i < 3; i++) begin
        d = rshr(vel * vec[i], 30);
        sum = longint'(cam_pos[i]) + sgn * d;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        cam_pos[i] = 32'(sum);
      end
    end
    res.pos_x = cam_pos[0];
    res.pos_y = cam_pos[1];
    res.pos_z = cam_pos[2];
    res.quat_w = quat_part(rshr(chy * chp, 46));
    res.quat_x = quat_part(rshr(chy * shp, 46));
    res.quat_y = quat_part(-rshr(shy * chp, 46));
    res.quat_z = quat_part(rshr(shy * shp, 46));
    res.yaw_deg = cam_yaw;
    res.pitch_deg = cam_pitch;
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Driver: a new item is offered only after the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_item_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      out_stall_i <= 1'b1;
      hold_request <= hold_request - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_item_t pose;
    out_item_t got;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      predict_pose(in_item_i, pose);
      pose_queue.push_back(pose);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = out_item_o;
      if (pose_queue.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        pose = pose_queue.pop_front();
        check_field("pos_x", pose.pos_x, got.pos_x);
        check_field("pos_y", pose.pos_y, got.pos_y);
        check_field("pos_z", pose.pos_z, got.pos_z);
        check_field("quat_w", pose.quat_w, got.quat_w);
        check_field("quat_x", pose.quat_x, got.quat_x);
        check_field("quat_y", pose.quat_y, got.quat_y);
        check_field("quat_z", pose.quat_z, got.quat_z);
        check_field("yaw_deg", pose.yaw_deg, got.yaw_deg);
        check_field("pitch_deg", pose.pitch_deg, got.pitch_deg);
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || pose_queue.size() != 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_MOVE_SPEED) cam_speed = val;
    else if (idx == REG_LOOK_SENS) cam_sens = val[19:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic in_item_t make_item(logic op, logic [2:0] dir, logic [15:0] dt,
                                         logic [15:0] dx, logic [15:0] dy);
    in_item_t it;
    it.op = op;
    it.direction = dir;
    it.delta_time = dt;
    it.mouse_dx = dx;
    it.mouse_dy = dy;
    return it;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'($urandom_range(40)) - 16'd20;
      default: return 16'($urandom);
    endcase
  endfunction

  // Runs of one direction mixed with look items, plus some stray codes.
  task automatic queue_random(int unsigned count);
    int unsigned n, run;
    logic [2:0] dir;
    in_item_t it;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) < 5) begin
        dir = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
        run = $urandom_range(1, 12);
        for (int k = 0; k < run; k++) begin
          it = make_item(OP_MOVE, dir, pick_word(), 16'($urandom), 16'($urandom));
          pending_items.push_back(it);
        end
        n += run;
      end else begin
        it = make_item(OP_LOOK, 3'($urandom), 16'($urandom), pick_word(), pick_word());
        pending_items.push_back(it);
        n++;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_item_i = '0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_request = 0;
    errors = 0;
    cycles = 0;
    cam_pos = '{0, 0, 0};
    cam_yaw = '0;
    cam_pitch = '0;
    cam_speed = SpeedRst;
    cam_sens = SensRst;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int d = DIR_FWD; d <= DirSpareB; d++)
      pending_items.push_back(make_item(OP_MOVE, 3'(d), 16'hFFFF, 16'h7FFF, 16'h8000));
    pending_items.push_back(make_item(OP_MOVE, DIR_FWD, 16'h0000, 16'h0, 16'h0));
    pending_items.push_back(make_item(OP_LOOK, DIR_UP, 16'hFFFF, 16'h7FFF, 16'h7FFF));
    pending_items.push_back(make_item(OP_LOOK, DIR_UP, 16'h0, 16'h8000, 16'h8000));
    pending_items.push_back(make_item(OP_LOOK, DIR_UP, 16'h0, 16'h0001, 16'hFFFF));
    pending_items.push_back(make_item(OP_LOOK, DIR_UP, 16'h0, 16'hFFFF, 16'h0001));
    for (int d = DIR_FWD; d <= DIR_DOWN; d++)
      pending_items.push_back(make_item(OP_MOVE, 3'(d), 16'h8000, 16'h0, 16'h0));
    wait_drained();

    write_reg(REG_MOVE_SPEED, 24'hFFFFFF);
    write_reg(REG_LOOK_SENS, 24'h0FFFFF);
    write_reg(RegSpareA, 24'h000001);
    write_reg(RegSpareB, 24'hABCDEF);
    // Long climbs at full speed drive the position into saturation.
    for (int k = 0; k < 140; k++)
      pending_items.push_back(make_item(OP_MOVE, DIR_UP, 16'hFFFF, 16'($urandom), 16'h0));
    queue_random(250);
    wait_drained();

    snd_idle_pct = 69;
    write_reg(REG_MOVE_SPEED, 24'd0);
    write_reg(REG_LOOK_SENS, 24'd0);
    queue_random(150);
    wait_drained();

    snd_idle_pct = 0;
    rcv_stall_pct = 69;
    write_reg(REG_MOVE_SPEED, SpeedRst);
    write_reg(REG_LOOK_SENS, 24'(SensRst));
    hold_request = 600;
    queue_random(300);
    wait_drained();

    snd_idle_pct = 27;
    rcv_stall_pct = 27;
    write_reg(REG_MOVE_SPEED, 24'($urandom));
    write_reg(REG_LOOK_SENS, 24'($urandom_range(20'hFFFFF)));
    for (int k = 0; k < 400; k++)
      pending_items.push_back(make_item(OP_MOVE, DIR_DOWN, 16'hFFFF, 16'h0, 16'h0));
    queue_random(150);
    wait_drained();

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/fcp_pkg.sv
src/fcp_cordic.sv
src/fly_camera_pose_update.sv
sim/tb_fly_camera_pose_update.sv
